>>> rtl/ppfa_pkg.sv
// ppfa_pkg: shared types and constants for the per-axis position pid force block
// no dependencies; imported by every module of the block
`default_nettype none

package ppfa_pkg;

	// register port
	localparam int unsigned REG_W     = 31;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BODY_MASS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 3'd4;

	localparam logic [REG_W-1:0] PROP_GAIN_RST  = 31'd0;
	localparam logic [REG_W-1:0] DERIV_GAIN_RST = 31'd0;
	localparam logic [REG_W-1:0] INTEG_GAIN_RST = 31'd0;
	localparam logic [REG_W-1:0] BODY_MASS_RST  = 31'd65536;
	localparam logic [REG_W-1:0] GRAVITY_RST    = 31'd642908;

	// vertical axis code and 0.0025 in Q0.32
	localparam logic [1:0]       VERTICAL_AXIS = 2'd2;
	localparam logic [REG_W-1:0] STEP_HALF_Q32 = 31'd10737418;

	typedef struct packed {
		logic [REG_W-1:0] prop_gain;
		logic [REG_W-1:0] deriv_gain;
		logic [REG_W-1:0] integ_gain;
		logic [REG_W-1:0] body_mass;
		logic [REG_W-1:0] gravity_accel;
	} cfg_regs_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MSTEP,
		ST_MDERIV,
		ST_MPROP,
		ST_MINTEG,
		ST_ACC,
		ST_MMASS,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MUL_STEP,
		MUL_DERIV,
		MUL_PROP,
		MUL_INTEG,
		MUL_MASS
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     calc_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     upd_integ;
		logic     acc_add;
		logic     acc_fin;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic axis_ok;
		logic out_busy;
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/position_pid_force_axis.sv
// position_pid_force_axis: per-axis position pid force command with anti-windup
// depends on ppfa_pkg, ppfa_cfg, ppfa_ctrl and ppfa_dp
//
//  port group  | direction | handshake           | payload
//  ------------+-----------+---------------------+----------------------------------------
//  in          | sink      | in_valid / in_stall | axis, position, target_position,
//              |           |                     | velocity, target_velocity, target_accel
//  out         | source    | out_valid/out_stall | axis_out, force_res
//  cfg         | sink      | cfg_we              | cfg_index, cfg_data
//
// a word for a valid axis goes from acceptance through an error step, five passes through
// the single shared 34x32 multiplier, an accumulator clamp step, the output load and the
// idle step that takes the next word
// a word for an axis with no state goes through error, output load and idle
// reset clears the sequencer, the output valid and the per-axis error and integral
// the result sits in an output register, so out_stall only holds the sequencer in
// its last step; in_stall is high from acceptance until that result is loaded
`default_nettype none

module position_pid_force_axis #(
	parameter int NUM_AXES = 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input word channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     axis,
	input  wire logic signed [31:0]             position,
	input  wire logic signed [31:0]             target_position,
	input  wire logic signed [31:0]             velocity,
	input  wire logic signed [31:0]             target_velocity,
	input  wire logic signed [31:0]             target_accel,
	// result word channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          axis_out,
	output logic signed [31:0]                  force_res,
	// register writes
	input  wire logic                           cfg_we,
	input  wire logic [ppfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ppfa_pkg::REG_W-1:0]     cfg_data
);
	import ppfa_pkg::*;

	cfg_regs_t regs;
	cmd_t      cmd;
	stat_t     stat;

	// gains, mass and gravity
	ppfa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// sequencer: error, step product, three gain products, clamp, mass product, output load
	ppfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic, per-axis state and output word register
	ppfa_dp #(
		.NUM_AXES (NUM_AXES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (regs),
		.stat            (stat),
		.axis            (axis),
		.position        (position),
		.target_position (target_position),
		.velocity        (velocity),
		.target_velocity (target_velocity),
		.target_accel    (target_accel),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.axis_out        (axis_out),
		.force_res       (force_res)
	);

endmodule

`default_nettype wire

>>> rtl/ppfa_cfg.sv
// ppfa_cfg: gain, mass and gravity registers behind the plain write port
// depends on ppfa_pkg
`default_nettype none

module ppfa_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ppfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ppfa_pkg::REG_W-1:0]     cfg_data,
	output ppfa_pkg::cfg_regs_t                 regs
);
	import ppfa_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.prop_gain     <= PROP_GAIN_RST;
			regs_q.deriv_gain    <= DERIV_GAIN_RST;
			regs_q.integ_gain    <= INTEG_GAIN_RST;
			regs_q.body_mass     <= BODY_MASS_RST;
			regs_q.gravity_accel <= GRAVITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN:  regs_q.prop_gain     <= cfg_data;
				REG_DERIV_GAIN: regs_q.deriv_gain    <= cfg_data;
				REG_INTEG_GAIN: regs_q.integ_gain    <= cfg_data;
				REG_BODY_MASS:  regs_q.body_mass     <= cfg_data;
				REG_GRAVITY:    regs_q.gravity_accel <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

>>> rtl/ppfa_ctrl.sv
// ppfa_ctrl: sequencer that steps one word through the shared multiplier
// depends on ppfa_pkg
`default_nettype none

module ppfa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire ppfa_pkg::stat_t stat,
	output ppfa_pkg::cmd_t      cmd
);
	import ppfa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.mul_sel = MUL_STEP;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_ERR;
				end
			end
			ST_ERR: begin
				cmd.calc_err = 1'b1;
				// an axis with no state goes straight out with zero force
				state_d = stat.axis_ok ? ST_MSTEP : ST_OUT;
			end
			ST_MSTEP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_STEP;
				state_d     = ST_MDERIV;
			end
			ST_MDERIV: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_DERIV;
				cmd.upd_integ = 1'b1;
				state_d       = ST_MPROP;
			end
			ST_MPROP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PROP;
				cmd.acc_add = 1'b1;
				state_d     = ST_MINTEG;
			end
			ST_MINTEG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INTEG;
				cmd.acc_add = 1'b1;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_add = 1'b1;
				cmd.acc_fin = 1'b1;
				state_d     = ST_MMASS;
			end
			ST_MMASS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MASS;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/ppfa_dp.sv
// ppfa_dp: error, integral, shared multiplier, accumulator and output register
// depends on ppfa_pkg; driven by ppfa_ctrl commands
`default_nettype none

module ppfa_dp #(
	parameter int NUM_AXES = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ppfa_pkg::cmd_t        cmd,
	input  wire ppfa_pkg::cfg_regs_t   cfg,
	output ppfa_pkg::stat_t            stat,
	input  wire logic [1:0]            axis,
	input  wire logic signed [31:0]    position,
	input  wire logic signed [31:0]    target_position,
	input  wire logic signed [31:0]    velocity,
	input  wire logic signed [31:0]    target_velocity,
	input  wire logic signed [31:0]    target_accel,
	input  wire logic                  out_stall,
	output logic                       out_valid,
	output logic [1:0]                 axis_out,
	output logic signed [31:0]         force_res
);
	import ppfa_pkg::*;

	localparam int AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam logic [3:0] NUM_AX_L = 4'(NUM_AXES);
	localparam logic signed [49:0] ACC_LIM  = 50'sd4294967295;
	localparam logic signed [49:0] F_MAX    = 50'sd2147483647;
	localparam logic signed [49:0] F_MIN    = -50'sd2147483648;

	function automatic logic [31:0] sat_diff(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			sat_diff = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			sat_diff = d[31:0];
		end
	endfunction

	// captured word
	logic [1:0]         axis_q;
	logic               axis_ok_q;
	logic signed [31:0] pos_q, tpos_q, vel_q, tvel_q, tacc_q;

	// per axis state
	logic signed [31:0] last_err_q [NUM_AXES];
	logic signed [31:0] integ_q    [NUM_AXES];

	logic signed [31:0] err_q, verr_q, ival_q;
	logic signed [32:0] esum_q;
	logic signed [65:0] p_q;
	logic signed [49:0] acc_q;

	logic               out_valid_q;
	logic [1:0]         axis_out_q;
	logic signed [31:0] force_q;

	logic [AX_W-1:0]    ax_idx;
	logic signed [33:0] mul_a;
	logic [REG_W-1:0]   mul_b;
	logic signed [65:0] prod;
	logic signed [65:0] p_rnd16, p_rnd32;
	logic signed [49:0] r16;
	logic signed [33:0] r32;
	logic signed [34:0] ival_raw, lim_pos, lim_neg;
	logic [33:0]        lim5;
	logic [REG_W-1:0]   lim_c;
	logic signed [31:0] ival_cl;
	logic signed [49:0] acc_init, acc_sum, acc_nxt;
	logic signed [31:0] force_sat;
	logic               vertical;

	assign ax_idx = AX_W'(axis_q);

	// shared multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MUL_STEP: begin
				mul_a = {esum_q[32], esum_q};
				mul_b = STEP_HALF_Q32;
			end
			MUL_DERIV: begin
				mul_a = {{2{verr_q[31]}}, verr_q};
				mul_b = cfg.deriv_gain;
			end
			MUL_PROP: begin
				mul_a = {{2{err_q[31]}}, err_q};
				mul_b = cfg.prop_gain;
			end
			MUL_INTEG: begin
				mul_a = {{2{ival_q[31]}}, ival_q};
				mul_b = cfg.integ_gain;
			end
			MUL_MASS: begin
				mul_a = acc_q[33:0];
				mul_b = cfg.body_mass;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * $signed({1'b0, mul_b});

	// round half up: add half, then floor
	assign p_rnd16 = p_q + 66'sd32768;
	assign p_rnd32 = p_q + 66'sd2147483648;
	assign r16     = p_rnd16[65:16];
	assign r32     = p_rnd32[65:32];

	// trapezoid step and anti-windup clamp
	assign ival_raw = {{3{integ_q[ax_idx][31]}}, integ_q[ax_idx]} + {r32[33], r32};
	assign lim5     = {3'b000, cfg.integ_gain} + {1'b0, cfg.integ_gain, 2'b00};
	assign lim_c    = (lim5 > 34'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : lim5[30:0];
	assign lim_pos  = $signed({4'b0000, lim_c});
	assign lim_neg  = -lim_pos;

	always_comb begin
		if (ival_raw > lim_pos) begin
			ival_cl = lim_pos[31:0];
		end else if (ival_raw < lim_neg) begin
			ival_cl = lim_neg[31:0];
		end else begin
			ival_cl = ival_raw[31:0];
		end
	end

	// acceleration sum
	assign vertical = (axis_q == VERTICAL_AXIS);
	assign acc_init = {{18{tacc_q[31]}}, tacc_q}
		- (vertical ? {19'b0, cfg.gravity_accel} : 50'sd0);
	assign acc_sum  = acc_q + r16;

	always_comb begin
		acc_nxt = acc_sum;
		if (cmd.acc_fin) begin
			if (acc_sum > ACC_LIM) begin
				acc_nxt = ACC_LIM;
			end else if (acc_sum < -ACC_LIM) begin
				acc_nxt = -ACC_LIM;
			end
		end
	end

	always_comb begin
		if (!axis_ok_q) begin
			force_sat = '0;
		end else if (r16 > F_MAX) begin
			force_sat = F_MAX[31:0];
		end else if (r16 < F_MIN) begin
			force_sat = F_MIN[31:0];
		end else begin
			force_sat = r16[31:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			axis_q    <= axis;
			axis_ok_q <= ({2'b00, axis} < NUM_AX_L);
			pos_q     <= position;
			tpos_q    <= target_position;
			vel_q     <= velocity;
			tvel_q    <= target_velocity;
			tacc_q    <= target_accel;
		end
		if (cmd.calc_err) begin
			err_q  <= sat_diff(tpos_q, pos_q);
			verr_q <= sat_diff(tvel_q, vel_q);
			esum_q <= {sat_diff(tpos_q, pos_q) >>> 31 != 0 ? 1'b1 : 1'b0,
				sat_diff(tpos_q, pos_q)} + {last_err_q[ax_idx][31], last_err_q[ax_idx]};
		end
		if (cmd.mul_en) begin
			p_q <= prod;
		end
		if (cmd.upd_integ) begin
			ival_q <= ival_cl;
			acc_q  <= acc_init;
		end else if (cmd.acc_add) begin
			acc_q <= acc_nxt;
		end
		if (cmd.load_out) begin
			axis_out_q <= axis_q;
			force_q    <= force_sat;
		end
	end

	// per axis state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				last_err_q[i] <= '0;
				integ_q[i]    <= '0;
			end
		end else if (cmd.upd_integ) begin
			last_err_q[ax_idx] <= err_q;
			integ_q[ax_idx]    <= ival_cl;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.axis_ok  = axis_ok_q;
	assign stat.out_busy = out_valid_q & out_stall;

	assign out_valid = out_valid_q;
	assign axis_out  = axis_out_q;
	assign force_res = force_q;

	// checks
	logic signed [34:0] ival_ext;
	assign ival_ext = {{3{ival_q[31]}}, ival_q};

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("output word overwritten while held");

	a_mul_axis: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> axis_ok_q)
		else $error("multiplier used for an axis with no state");

	a_windup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_integ |=> (ival_ext <= lim_pos) && (ival_ext >= lim_neg))
		else $error("integral outside anti-windup limit");

	a_acc_lim: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_fin |=> (acc_q <= ACC_LIM) && (acc_q >= -ACC_LIM))
		else $error("acceleration sum not clamped");

endmodule

`default_nettype wire
